/* hdl/first_fit_heap_allocator_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Wraps the assertions so that they drop out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// assert that prop holds at every clock edge outside reset
`define FFH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert that cond implies prop in the next cycle
`define FFH_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define FFH_ASSERT(label, clk, rst, prop, msg)
`define FFH_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

/* hdl/ffha_pkg.sv */
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

   localparam int MaxArena    = 4096;
   localparam int HeaderBytes = 8;
   localparam int AddrW       = $clog2(MaxArena);     // header offset bits
   localparam int FieldW      = 13;
   localparam int HdrW        = 1 + FieldW + AddrW;   // free, size, next
   localparam int StepW       = AddrW + 1;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INFO  = 2'd2;

   localparam logic [9:0]        BlocksMax = 10'h3FF;
   localparam logic [FieldW-1:0] BytesMax  = 13'h1FFF;

   typedef struct packed {
      logic              free;
      logic [FieldW-1:0] size;
      logic [AddrW-1:0]  next;
   } hdr_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [FieldW-1:0] request_size;
      logic [FieldW-1:0] block_address;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [11:0]       address;
      logic [9:0]        used_blocks;
      logic [FieldW-1:0] used_bytes;
      logic [FieldW-1:0] largest_free;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_CHK,
      ST_WR1,
      ST_WR2,
      ST_FRD_NX,
      ST_FCHK,
      ST_DONE
   } state_type;

   // memory command from the walker to the store
   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      hdr_type          wr_data;
      logic [AddrW-1:0] rd_addr;
   } mem_cmd_type;

endpackage

/* hdl/ffha_if.sv */
// ---------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels carrying request and result beats.
// ---------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/first_fit_heap_allocator_core.sv */
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// Heap allocator walking an address-ordered header chain in one RAM.
// ---------------------------------------------------------------------------
// Steps: each header visited is read (read issue, then check of the
//   registered read data), then a split write or a merge where needed,
//   then the result register is loaded; a rejected free or func skips the walk.
// Throughput: one request at a time; the next beat is taken the cycle after
//   the result beat leaves.
// Reset: synchronous; header 0 reads free and last, arena_size = 4096,
//   no clearing pass.
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ffha_req_if.sink          req,
   ffha_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [FieldW-1:0] csr_wr_data
);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxArena - 1);
   localparam logic [FieldW+1:0] HdrS    = (FieldW+2)'(HeaderBytes);

   state_type state_ff, state_in;
   logic [FieldW-1:0] arena_ff;
   req_type           op_ff, op_in;
   logic [AddrW-1:0]  cur_ff, cur_in;     // header being read
   logic [AddrW-1:0]  prev_ff, prev_in;
   hdr_type           ph_ff, ph_in;       // previous header
   hdr_type           ch_ff, ch_in;       // current header (for free)
   logic [StepW-1:0]  steps_ff, steps_in;
   logic [10:0]       blk_ff, blk_in;
   logic [13:0]       byt_ff, byt_in;
   logic [FieldW-1:0] best_ff, best_in;
   // pending second write
   logic              w2_en_ff, w2_en_in;
   logic [AddrW-1:0]  w2_addr_ff, w2_addr_in;
   hdr_type           w2_data_ff, w2_data_in;
   rsp_type           out_ff, out_in;
   logic              out_v_ff, out_v_in;
   mem_cmd_type       cmd;
   hdr_type           rh;

   ffha_store u_store (.clock(clock), .reset(reset), .cmd(cmd), .rd_hdr(rh));

   // -------- chain arithmetic on the freshly read header --------
   logic              last;
   logic signed [FieldW+1:0] room;     // payload space of current block
   logic [FieldW-1:0] arena_len;
   logic [FieldW+1:0] pay;
   logic              fits;
   logic              goal_hit;
   logic              past_goal;       // chain is address ordered
   logic [AddrW-1:0]  goal;

   always_comb begin
      arena_len = (arena_ff < FieldW'(MaxArena)) ? arena_ff : FieldW'(MaxArena);
      last = (rh.next == cur_ff);
      if (last) begin
         room = $signed({2'b00, arena_len}) - $signed({2'b00, 1'b0, cur_ff})
                - $signed(HdrS);
      end else begin
         room = $signed({3'b000, rh.next}) - $signed({3'b000, cur_ff}) - $signed(HdrS);
      end
      fits = (room >= $signed({1'b0, 1'b0, op_ff.request_size}));
      pay  = {3'b000, cur_ff} + HdrS;
      goal = AddrW'(op_ff.block_address - FieldW'(HeaderBytes));
      goal_hit  = ({1'b0, cur_ff} == (op_ff.block_address - FieldW'(HeaderBytes)));
      past_goal = ({1'b0, cur_ff} > (op_ff.block_address - FieldW'(HeaderBytes)));
   end

   // split header location and leftover
   logic [FieldW+1:0] nb_full;
   logic              do_split;
   always_comb begin
      nb_full  = pay + {2'b00, op_ff.request_size};
      do_split = (room - $signed({2'b00, op_ff.request_size})) > $signed(HdrS);
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && !out_v_ff) begin
               if (req.payload.func == FUNC_ALLOC || req.payload.func == FUNC_INFO ||
                   (req.payload.func == FUNC_FREE &&
                    req.payload.block_address >= FieldW'(HeaderBytes))) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = ST_RD;
            if (op_ff.func == FUNC_ALLOC) begin
               if (rh.free && fits) begin
                  if (pay > {3'b000, LastAddr}) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = do_split ? ST_WR2 : ST_DONE;
                  end
               end else if (last) begin
                  state_in = ST_DONE;
               end
            end else if (op_ff.func == FUNC_INFO) begin
               if (last) state_in = ST_DONE;
            end else begin
               if (goal_hit) begin
                  state_in = (rh.free || last) ? ST_DONE : ST_FRD_NX;
               end else if (last || past_goal) begin
                  state_in = ST_DONE;
               end
            end
            if (steps_ff == StepW'(MaxArena) && state_in == ST_RD) state_in = ST_DONE;
         end
         ST_FRD_NX: begin
            state_in = ST_FCHK;
         end
         ST_FCHK, ST_WR1, ST_WR2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_v_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- datapath / memory commands ----------------
   always_comb begin
      op_in      = op_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      ph_in      = ph_ff;
      ch_in      = ch_ff;
      steps_in   = steps_ff;
      blk_in     = blk_ff;
      byt_in     = byt_ff;
      best_in    = best_ff;
      w2_en_in   = 1'b0;
      w2_addr_in = w2_addr_ff;
      w2_data_in = w2_data_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff;
      cmd        = '{wr_en: 1'b0, wr_addr: '0, wr_data: '0, rd_addr: cur_ff};
      if (rsp.ready) out_v_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && !out_v_ff) begin
               op_in    = req.payload;
               cur_in   = '0;
               prev_in  = '0;
               steps_in = '0;
               blk_in   = '0;
               byt_in   = '0;
               best_in  = '0;
               out_in   = '0;
               cmd.rd_addr = '0;
            end
         end
         ST_RD, ST_FRD_NX: begin
            cmd.rd_addr = cur_ff;   // read issued; data next cycle
         end
         ST_CHK: begin
            steps_in = steps_ff + 1'b1;
            ch_in    = rh;
            prev_in  = cur_ff;
            ph_in    = rh;
            cur_in   = rh.next;
            if (op_ff.func == FUNC_ALLOC) begin
               if (rh.free && fits && pay <= {3'b000, LastAddr}) begin
                  out_in.ok      = 1'b1;
                  out_in.address = pay[11:0];
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = cur_ff;
                  cmd.wr_data = '{free: 1'b0, size: op_ff.request_size,
                                  next: do_split ? AddrW'(nb_full) : rh.next};
                  w2_en_in   = do_split;
                  w2_addr_in = AddrW'(nb_full);
                  w2_data_in = '{free: 1'b1, size: '0,
                                 next: last ? AddrW'(nb_full) : rh.next};
               end
            end else if (op_ff.func == FUNC_INFO) begin
               if (rh.free) begin
                  if (room > 0 && room > $signed({2'b00, best_ff})) begin
                     best_in = FieldW'(room);
                  end
               end else begin
                  blk_in = blk_ff + 1'b1;
                  byt_in = byt_ff + {1'b0, rh.size};
               end
               if (last) out_in.ok = 1'b1;
            end else begin
               // free: keep previous header while walking
               prev_in = (goal_hit) ? prev_ff : cur_ff;
               ph_in   = (goal_hit) ? ph_ff : rh;
               if (goal_hit && !rh.free && last) begin
                  out_in.ok = 1'b1;
                  cmd.wr_en = 1'b1;
                  if (ph_ff.free && steps_ff != '0) begin
                     cmd.wr_addr = prev_ff;
                     cmd.wr_data = '{free: 1'b1, size: ph_ff.size, next: prev_ff};
                  end else begin
                     cmd.wr_addr = cur_ff;
                     cmd.wr_data = '{free: 1'b1, size: '0, next: rh.next};
                  end
               end
            end
         end
         ST_FCHK: begin
            // rh = next header, ch_ff = goal header, ph_ff = prev
            out_in.ok = 1'b1;
            cmd.wr_en = 1'b1;
            if (rh.free) begin
               if (ph_ff.free && goal != prev_ff) begin
                  cmd.wr_addr = prev_ff;
                  cmd.wr_data = '{free: 1'b1, size: ph_ff.size,
                                  next: (rh.next == cur_ff) ? prev_ff : rh.next};
               end else begin
                  cmd.wr_addr = goal;
                  cmd.wr_data = '{free: 1'b1, size: '0,
                                  next: (rh.next == cur_ff) ? goal : rh.next};
               end
            end else begin
               if (ph_ff.free && goal != prev_ff) begin
                  cmd.wr_addr = prev_ff;
                  cmd.wr_data = '{free: 1'b1, size: ph_ff.size, next: ch_ff.next};
               end else begin
                  cmd.wr_addr = goal;
                  cmd.wr_data = '{free: 1'b1, size: '0, next: ch_ff.next};
               end
            end
         end
         ST_WR2: begin
            cmd.wr_en   = w2_en_ff;
            cmd.wr_addr = w2_addr_ff;
            cmd.wr_data = w2_data_ff;
         end
         ST_DONE: begin
            if (op_ff.func == FUNC_INFO) begin
               out_in.used_blocks  = (blk_ff > 11'(BlocksMax)) ? BlocksMax : blk_ff[9:0];
               out_in.used_bytes   = (byt_ff > 14'(BytesMax)) ? BytesMax : byt_ff[12:0];
               out_in.largest_free = best_ff;
            end
            if (!out_v_ff || rsp.ready) out_v_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         arena_ff <= FieldW'(MaxArena);
         out_v_ff <= 1'b0;
         w2_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         w2_en_ff <= w2_en_in;
         if (csr_wr_en) arena_ff <= csr_wr_data;
      end
      op_ff      <= op_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      ph_ff      <= ph_in;
      ch_ff      <= ch_in;
      steps_ff   <= steps_in;
      blk_ff     <= blk_in;
      byt_ff     <= byt_in;
      best_ff    <= best_in;
      w2_addr_ff <= w2_addr_in;
      w2_data_ff <= w2_data_in;
      out_ff     <= out_in;
   end

   assign req.ready   = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp.valid   = out_v_ff;
   assign rsp.payload = out_ff;

   `FFH_ASSERT(a_rdy_idle, clock, reset, !(req.ready && state_ff != ST_IDLE), "ready outside idle")
   `FFH_ASSERT_NEXT(a_take, clock, reset, req.valid && req.ready, state_ff != ST_IDLE, "beat lost")
   `FFH_ASSERT_NEXT(a_split, clock, reset, w2_en_in, state_ff == ST_WR2, "split write dropped")
endmodule

/* hdl/ffha_ram.sv */
// ---------------------------------------------------------------------------
// ffha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module ffha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/ffha_store.sv */
// ---------------------------------------------------------------------------
// ffha_store
// Header store: RAM plus the reset image of entry zero.
// ---------------------------------------------------------------------------
module ffha_store import ffha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_cmd_type cmd,
   output hdr_type     rd_hdr
);
   // entry zero reads as free/last until first write after reset
   logic     z_valid_ff, z_valid_in;
   logic     rd_zero_ff;
   logic [HdrW-1:0] raw;

   ffha_ram #(.Width(HdrW), .Depth(MaxArena)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_data),
      .rd_addr (cmd.rd_addr),
      .rd_data (raw)
   );

   always_comb begin
      z_valid_in = z_valid_ff;
      if (cmd.wr_en && cmd.wr_addr == '0) begin
         z_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_valid_ff <= 1'b0;
      end else begin
         z_valid_ff <= z_valid_in;
      end
      rd_zero_ff <= (cmd.rd_addr == '0) && !z_valid_ff;
   end

   always_comb begin
      if (rd_zero_ff) begin
         rd_hdr = '{free: 1'b1, size: '0, next: '0};
      end else begin
         rd_hdr = hdr_type'(raw);
      end
   end
endmodule

/* bench/ffha_checker.sv */
// ---------------------------------------------------------------------------
// ffha_checker
// Watches the request and result channels of the heap allocator, keeps its
// own copy of the header chain and checks every result beat in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ffha_checker import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ffha_req_if               req_ch,
   ffha_rsp_if               rsp_ch,
   input  logic              csr_wr_en,
   input  logic [FieldW-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending,
   output int                checked
);

   bit                hfree [MaxArena];
   logic [FieldW-1:0] hsize [MaxArena];
   logic [AddrW-1:0]  hnext [MaxArena];
   logic [FieldW-1:0] arena_bytes;
   rsp_type           awaited_rsp [$];

   function automatic bit is_tail(int b);
      return hnext[b] == b;
   endfunction

   function automatic int arena_len();
      return (arena_bytes < MaxArena) ? int'(arena_bytes) : MaxArena;
   endfunction

   function automatic bit take_block(int b, int room, int s, bit tail, output int addr);
      int pay, nb;
      pay = b + HeaderBytes;
      addr = 0;
      if (pay > 4095) return 0;
      hfree[b] = 0;
      hsize[b] = FieldW'(s);
      if (room - s > HeaderBytes) begin
         nb = pay + s;
         hfree[nb] = 1;
         hsize[nb] = '0;
         hnext[nb] = tail ? AddrW'(nb) : hnext[b];
         hnext[b] = AddrW'(nb);
      end
      addr = pay;
      return 1;
   endfunction

   function automatic bit alloc_first_fit(int s, output int addr);
      int cur, b, steps, room;
      cur = 0;
      steps = 0;
      addr = 0;
      while (!is_tail(cur) && steps < MaxArena) begin
         b = cur;
         steps++;
         cur = hnext[b];
         if (hfree[b]) begin
            room = int'(hnext[b]) - b - HeaderBytes;
            if (room >= s) return take_block(b, room, s, 0, addr);
         end
      end
      if (!is_tail(cur) || !hfree[cur]) return 0;
      room = arena_len() - cur - HeaderBytes;
      if (room >= s) return take_block(cur, room, s, 1, addr);
      return 0;
   endfunction

   function automatic bit release_block(int p);
      int goal, prv, cur, steps, nx;
      bit nx_tail;
      if (p < HeaderBytes) return 0;
      goal = p - HeaderBytes;
      prv = 0;
      cur = 0;
      steps = 0;
      while (!is_tail(cur) && steps < MaxArena) begin
         steps++;
         if (cur == goal) begin
            if (hfree[cur]) return 0;
            nx = hnext[cur];
            nx_tail = is_tail(nx);
            if (hfree[nx]) begin
               if (hfree[prv]) hnext[prv] = nx_tail ? AddrW'(prv) : hnext[nx];
               else begin
                  hnext[cur] = nx_tail ? AddrW'(cur) : hnext[nx];
                  hfree[cur] = 1;
                  hsize[cur] = '0;
               end
            end else begin
               if (hfree[prv]) hnext[prv] = hnext[cur];
               else begin
                  hfree[cur] = 1;
                  hsize[cur] = '0;
               end
            end
            return 1;
         end
         prv = cur;
         cur = hnext[cur];
      end
      if (cur != goal || !is_tail(cur) || hfree[cur]) return 0;
      if (hfree[prv]) hnext[prv] = AddrW'(prv);
      else begin
         hfree[cur] = 1;
         hsize[cur] = '0;
      end
      return 1;
   endfunction

   function automatic void usage_report(ref rsp_type r);
      int blocks, bytes, best, cur, steps, sp;
      blocks = 0; bytes = 0; best = 0; cur = 0; steps = 0;
      while (!is_tail(cur) && steps < MaxArena) begin
         steps++;
         if (hfree[cur]) begin
            sp = int'(hnext[cur]) - cur - HeaderBytes;
            if (sp > best) best = sp;
         end else begin
            blocks++;
            bytes += hsize[cur];
         end
         cur = hnext[cur];
      end
      if (hfree[cur]) begin
         sp = arena_len() - cur - HeaderBytes;
         if (sp > best) best = sp;
      end else begin
         blocks++;
         bytes += hsize[cur];
      end
      r.used_blocks  = (blocks > 1023) ? BlocksMax : 10'(blocks);
      r.used_bytes   = (bytes > 8191) ? BytesMax : FieldW'(bytes);
      r.largest_free = (best > 8191) ? BytesMax : FieldW'(best);
   endfunction

   function automatic rsp_type heap_outcome(req_type q);
      rsp_type r;
      int addr;
      r = '0;
      case (q.func)
         FUNC_ALLOC: begin
            if (alloc_first_fit(int'(q.request_size), addr)) begin
               r.ok = 1;
               r.address = 12'(addr);
            end
         end
         FUNC_FREE: r.ok = release_block(int'(q.block_address));
         FUNC_INFO: begin
            r.ok = 1;
            usage_report(r);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_field(string name, logic [12:0] exp_v, logic [12:0] got_v);
      $display("%0t ns: mismatch in %s: expected %0d, actual %0d",
               $time, name, exp_v, got_v);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type exp_r, got_r;
      if (reset) begin
         for (int i = 0; i < MaxArena; i++) begin
            hfree[i] = 0;
            hsize[i] = '0;
            hnext[i] = '0;
         end
         hfree[0] = 1;
         arena_bytes = 13'd4096;
         awaited_rsp.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (csr_wr_en) arena_bytes = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_r = rsp_ch.payload;
            if (awaited_rsp.size() == 0) begin
               $display("%0t ns: result beat with none expected, actual %h", $time, got_r);
               fail_count++;
            end else begin
               exp_r = awaited_rsp.pop_front();
               checked++;
               if (got_r.ok !== exp_r.ok) report_field("ok", exp_r.ok, got_r.ok);
               if (got_r.address !== exp_r.address)
                  report_field("address", exp_r.address, got_r.address);
               if (got_r.used_blocks !== exp_r.used_blocks)
                  report_field("used_blocks", exp_r.used_blocks, got_r.used_blocks);
               if (got_r.used_bytes !== exp_r.used_bytes)
                  report_field("used_bytes", exp_r.used_bytes, got_r.used_bytes);
               if (got_r.largest_free !== exp_r.largest_free)
                  report_field("largest_free", exp_r.largest_free, got_r.largest_free);
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited_rsp.push_back(heap_outcome(req_ch.payload));
      end
      pending = awaited_rsp.size();
   end

endmodule

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the first-fit heap allocator core.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ffha_pkg::*;

   localparam longint CycleLimit = 40_000_000;
   localparam logic [1:0] FuncUnknown = 2'd3;    // no such operation

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_wr_en = 0;
   logic [FieldW-1:0] csr_wr_data = '0;
   int                fail_count, pending, checked;
   longint            cycles = 0;
   int                sent = 0;
   bit                no_idle = 0;     // stretches where both sides run flat out
   int                live_addr [$];   // payload offsets handed out, candidates to free

   ffha_req_if req_ch ();
   ffha_rsp_if rsp_ch ();

   first_fit_heap_allocator_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ffha_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // collect addresses from successful allocations for later frees
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.payload.ok &&
          rsp_ch.payload.address != 0)
         live_addr.push_back(int'(rsp_ch.payload.address));
   end

   // result side: random stall per beat, ready held until the beat goes
   initial begin
      int stall;
      rsp_ch.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // one request beat: optional gap, then hold valid until accepted
   task automatic send_req(logic [1:0] f, int s, int a);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.payload.func = f;
      req_ch.payload.request_size = FieldW'(s);
      req_ch.payload.block_address = FieldW'(a);
      req_ch.valid = 1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent++;
   endtask

   // drain: lower valid and wait for every outstanding result
   task automatic drain();
      req_ch.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_arena(int v);
      drain();
      csr_wr_data = FieldW'(v);
      csr_wr_en = 1;
      @(negedge clock);
      csr_wr_en = 0;
      @(negedge clock);
   endtask

   // mostly small sizes keep chains short; a few large ones hit the extremes
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 64);
      if (r < 90) return $urandom_range(0, 512);
      if (r < 98) return $urandom_range(0, 4096);
      return $urandom_range(0, 8191);
   endfunction

   task automatic random_item();
      int r, k, a;
      r = $urandom_range(0, 99);
      if (r < 45) send_req(FUNC_ALLOC, pick_size(), $urandom_range(0, 8191));
      else if (r < 80) begin
         if (live_addr.size() > 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, live_addr.size() - 1);
            a = live_addr[k];
            // leave a few in the pool so double frees happen too
            if ($urandom_range(0, 9) != 0) live_addr.delete(k);
         end else a = $urandom_range(0, 8191);
         send_req(FUNC_FREE, $urandom_range(0, 8191), a);
      end else if (r < 95) send_req(FUNC_INFO, $urandom_range(0, 8191), $urandom_range(0, 8191));
      else send_req(FuncUnknown, $urandom_range(0, 8191), $urandom_range(0, 8191));
   endtask

   initial begin
      int arena_plan [5] = '{8, 8191, 64, 1000, 4096};
      req_ch.valid = 0;
      req_ch.payload = '0;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: empty heap, extremes, coalescing, bad frees, unknown op
      send_req(FUNC_INFO, 0, 0);
      send_req(FUNC_ALLOC, 8191, 0);          // too big
      send_req(FUNC_ALLOC, 4088, 0);          // whole arena, tail taken
      send_req(FUNC_ALLOC, 0, 0);             // tail in use, must fail
      send_req(FUNC_INFO, 0, 0);
      send_req(FUNC_FREE, 0, 8);
      send_req(FUNC_FREE, 0, 8);              // already free
      send_req(FUNC_FREE, 0, 3);              // below header
      send_req(FUNC_FREE, 0, 8191);
      send_req(FuncUnknown, 8191, 8191);      // unknown op
      send_req(FUNC_ALLOC, 16, 0);            // 8
      send_req(FUNC_ALLOC, 16, 0);            // 32
      send_req(FUNC_ALLOC, 16, 0);            // 56
      send_req(FUNC_ALLOC, 0, 0);             // 80, zero size
      send_req(FUNC_FREE, 0, 33);             // not a payload
      send_req(FUNC_FREE, 0, 32);             // both neighbors used
      send_req(FUNC_FREE, 0, 8);              // merges with the next block
      send_req(FUNC_FREE, 0, 56);             // merges with the previous block
      send_req(FUNC_INFO, 0, 0);
      send_req(FUNC_FREE, 0, 80);             // tail-side block
      send_req(FUNC_ALLOC, 4070, 0);
      send_req(FUNC_INFO, 0, 0);
      drain();                                // full stop before random part

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) write_arena(arena_plan[ph-1]);
         for (int i = 0; i < 300; i++) begin
            if (i % 75 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == 150) drain();
            random_item();
         end
         no_idle = 0;
      end

      drain();
      repeat (200) @(negedge clock);
      $display("sent %0d requests over 6 arena sizes (8 to 8191), %0d results checked",
               sent, checked);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* first_fit_heap_allocator_core.f */
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_if.sv
hdl/ffha_ram.sv
hdl/ffha_store.sv
hdl/first_fit_heap_allocator_core.sv
bench/ffha_checker.sv
bench/tb.sv
